>>> sv/lct_pkg.sv
// Shared types and constants of the LFU cache table.
package lct_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic [VALUE_W-1:0] READ_MISS  = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] READ_NONE  = 32'h0000_0000;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } opcode_t;

    // Bit positions of the result flags in the output tuser.
    localparam int RES_HIT_BIT     = 0;
    localparam int RES_EVICTED_BIT = 1;
    localparam int RES_FLAGS_W     = 2;

endpackage

>>> sv/lfu_cache_table.sv
// Top level of the LFU cache table with LRU tie-break.
//
//  Channel  Direction  Fields (lowest bit first)
//  s_*      in         tdata: lookup_key[31:0], write_value[63:32]; tuser: opcode
//  m_*      out        tdata: read_value[31:0]; tuser: hit, evicted
//  cfg_*    in         cfg_wdata: capacity_in_use
//
// Each transfer waits in the input register and then moves to the result register once that
// is empty or being taken; one item passes per cycle while m_tready stays high.
// The rate rests on the combinational key compare and victim minimum tree over all entries.
// Reset empties the cache at once and sets the capacity to sixteen.
// A stalled result holds the pipeline; the input side keeps taking one item while it waits.
module lfu_cache_table #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,   // lookup_key, write_value
    input  logic                           s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lct_pkg::VALUE_W-1:0]    m_tdata,   // read_value
    output logic [lct_pkg::RES_FLAGS_W-1:0] m_tuser,  // hit, evicted
    input  logic                           cfg_wen,
    input  logic [lct_pkg::CAP_W-1:0]      cfg_wdata  // capacity_in_use
);

    localparam int RB  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FB  = $clog2(ENTRIES + 1);
    localparam int CW  = (FB > lct_pkg::CAP_W) ? FB : lct_pkg::CAP_W;
    localparam int P   = 1 << RB;
    localparam int KW  = lct_pkg::KEY_W;
    localparam int VW  = lct_pkg::VALUE_W;

    logic                   in_valid_reg;
    lct_pkg::opcode_t       in_op_reg;
    logic [KW-1:0]          in_key_reg;
    logic [VW-1:0]          in_val_reg;

    logic                   out_valid_reg;
    logic [VW-1:0]          out_value_reg;
    logic                   out_hit_reg;
    logic                   out_evicted_reg;

    logic [lct_pkg::CAP_W-1:0] capacity_reg;
    logic [FB-1:0]          fill_reg;
    logic [FB-1:0]          fill_next;

    logic [ENTRIES-1:0]     valid_reg;
    logic [ENTRIES-1:0]     valid_next;
    logic [KW-1:0]          key_reg   [ENTRIES];
    logic [KW-1:0]          key_next  [ENTRIES];
    logic [VW-1:0]          value_reg [ENTRIES];
    logic [VW-1:0]          value_next[ENTRIES];
    logic [COUNT_BITS-1:0]  count_reg [ENTRIES];
    logic [COUNT_BITS-1:0]  count_next[ENTRIES];
    logic [RB-1:0]          rank_reg  [ENTRIES];
    logic [RB-1:0]          rank_next [ENTRIES];

    logic                   fire;
    logic [ENTRIES-1:0]     match;
    logic                   found;
    logic [VW-1:0]          hit_value;
    logic [RB-1:0]          hit_rank;
    logic [CW-1:0]          cap_ext;
    logic [CW-1:0]          cap_eff;
    logic [CW-1:0]          fill_ext;
    logic                   is_put;
    logic                   cap_zero;
    logic                   do_touch;
    logic                   do_insert;
    logic                   do_evict;
    logic [ENTRIES-1:0]     vict_hot;
    logic [RB-1:0]          vict_rank;
    logic [ENTRIES-1:0]     free_vec;
    logic [ENTRIES-1:0]     slot_hot;
    logic [VW-1:0]          read_value;

    logic [COUNT_BITS-1:0]  t_cnt[2*P];
    logic [RB-1:0]          t_rnk[2*P];
    logic [RB-1:0]          t_idx[2*P];
    logic                   t_ok [2*P];

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser[lct_pkg::RES_HIT_BIT]     = out_hit_reg;
    assign m_tuser[lct_pkg::RES_EVICTED_BIT] = out_evicted_reg;

    // Victim search: lowest use count, oldest among equals, as a binary tree.
    always_comb
    begin
        for (int i = 0; i < P; i++)
        begin
            if (i < ENTRIES)
            begin
                t_ok[P+i]  = valid_reg[i];
                t_cnt[P+i] = count_reg[i];
                t_rnk[P+i] = rank_reg[i];
            end
            else
            begin
                t_ok[P+i]  = 1'b0;
                t_cnt[P+i] = '0;
                t_rnk[P+i] = '0;
            end
            t_idx[P+i] = RB'(i);
        end
        for (int n = P - 1; n >= 1; n--)
        begin
            if (t_ok[2*n+1] && (!t_ok[2*n] || (t_cnt[2*n+1] < t_cnt[2*n]) ||
                ((t_cnt[2*n+1] == t_cnt[2*n]) && (t_rnk[2*n+1] > t_rnk[2*n]))))
            begin
                t_ok[n]  = t_ok[2*n+1];
                t_cnt[n] = t_cnt[2*n+1];
                t_rnk[n] = t_rnk[2*n+1];
                t_idx[n] = t_idx[2*n+1];
            end
            else
            begin
                t_ok[n]  = t_ok[2*n];
                t_cnt[n] = t_cnt[2*n];
                t_rnk[n] = t_rnk[2*n];
                t_idx[n] = t_idx[2*n];
            end
        end
        t_ok[0]  = 1'b0;
        t_cnt[0] = '0;
        t_rnk[0] = '0;
        t_idx[0] = '0;
    end

    always_comb
    begin
        hit_value = '0;
        hit_rank  = '0;
        vict_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == in_key_reg);
            if (match[i])
            begin
                hit_value = hit_value | value_reg[i];
                hit_rank  = hit_rank | rank_reg[i];
            end
        end
        found = |match;

        cap_ext  = CW'(capacity_reg);
        cap_eff  = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
        fill_ext = CW'(fill_reg);
        is_put   = (in_op_reg == lct_pkg::OP_PUT);
        cap_zero = (cap_eff == '0);

        do_touch  = found && (!is_put || !cap_zero);
        do_insert = is_put && !found && !cap_zero;
        do_evict  = do_insert && (fill_ext >= cap_eff) && t_ok[1];

        for (int i = 0; i < ENTRIES; i++)
        begin
            vict_hot[i] = do_evict && (t_idx[1] == RB'(i));
            if (vict_hot[i])
            begin
                vict_rank = vict_rank | rank_reg[i];
            end
        end
        free_vec = ~valid_reg | vict_hot;
        slot_hot = free_vec & (~free_vec + ENTRIES'(1));

        if (!is_put)
        begin
            read_value = found ? hit_value : lct_pkg::READ_MISS;
        end
        else
        begin
            read_value = lct_pkg::READ_NONE;
        end

        fill_next = fill_reg;
        if (do_insert && !do_evict)
        begin
            fill_next = fill_reg + FB'(1);
        end

        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            count_next[i] = count_reg[i];
            rank_next[i]  = rank_reg[i];
            if (do_touch)
            begin
                if (match[i])
                begin
                    rank_next[i] = '0;
                    if (count_reg[i] != '1)
                    begin
                        count_next[i] = count_reg[i] + COUNT_BITS'(1);
                    end
                    if (is_put)
                    begin
                        value_next[i] = in_val_reg;
                    end
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + RB'(1);
                end
            end
            else if (do_insert)
            begin
                if (slot_hot[i])
                begin
                    valid_next[i] = 1'b1;
                    key_next[i]   = in_key_reg;
                    value_next[i] = in_val_reg;
                    count_next[i] = COUNT_BITS'(1);
                    rank_next[i]  = '0;
                end
                else if (vict_hot[i])
                begin
                    valid_next[i] = 1'b0;
                end
                else if (valid_reg[i])
                begin
                    if (do_evict && (rank_reg[i] > vict_rank))
                    begin
                        rank_next[i] = rank_reg[i];
                    end
                    else
                    begin
                        rank_next[i] = rank_reg[i] + RB'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= lct_pkg::CAP_RESET;
            fill_reg      <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                fill_reg      <= fill_next;
                valid_reg     <= valid_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wen)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg  <= lct_pkg::opcode_t'(s_tuser);
            in_key_reg <= s_tdata[KW-1:0];
            in_val_reg <= s_tdata[KW+VW-1:KW];
        end
        if (fire)
        begin
            out_value_reg   <= read_value;
            out_hit_reg     <= found;
            out_evicted_reg <= do_evict;
            for (int i = 0; i < ENTRIES; i++)
            begin
                key_reg[i]   <= key_next[i];
                value_reg[i] <= value_next[i];
                count_reg[i] <= count_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

endmodule

>>> sv/lct_checker.sv
// Port-level checks of the LFU cache table result stream, bound to the top level.
module lct_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lct_pkg::VALUE_W-1:0]      m_tdata,
    input logic [lct_pkg::RES_FLAGS_W-1:0]  m_tuser
);

    // An eviction only happens on a miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[lct_pkg::RES_EVICTED_BIT] && m_tuser[lct_pkg::RES_HIT_BIT]))
    else $error("Eviction reported together with a hit.");

    // An eviction comes from a put, which always returns zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[lct_pkg::RES_EVICTED_BIT] |-> m_tdata == lct_pkg::READ_NONE)
    else $error("Evicting transfer carries a nonzero read value.");

    // A miss without eviction returns either the miss marker or zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[lct_pkg::RES_HIT_BIT] && !m_tuser[lct_pkg::RES_EVICTED_BIT]
        |-> m_tdata == lct_pkg::READ_MISS || m_tdata == lct_pkg::READ_NONE)
    else $error("Miss returned a value other than the miss marker or zero.");

    // A stalled result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed before transfer.");

endmodule

bind lfu_cache_table lct_checker u_lct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
